// File: rtl/sbc_pkg.sv
// Shared types, constants and round functions for the Serpent block cipher.
package sbc_pkg;

    localparam int ROUNDS_DEF  = 32;
    localparam int SUBKEYS_DEF = 33;
    localparam logic [31:0] GOLDEN_PHI = 32'h9e3779b9;

    localparam logic [1:0] CFG_KEY0 = 2'd0;
    localparam logic [1:0] CFG_KEY1 = 2'd1;
    localparam logic [1:0] CFG_KEY2 = 2'd2;
    localparam logic [1:0] CFG_KEY3 = 2'd3;
    localparam int CFG_IDX_W = 2;

    typedef struct packed {
        logic        mode;
        logic [63:0] block_low;
        logic [63:0] block_high;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       mode;
        logic [5:0] round;
        logic [5:0] rk_round;
        logic       final_step;
        logic       kx_load;
        logic       kx_step;
        logic [5:0] kx_idx;
    } dp_cmd_t;

    typedef logic [3:0] nib_t;

    function automatic nib_t sbox(input logic [2:0] b, input nib_t v);
        logic [63:0] row;
        case (b)
            3'd0: row = {4'd12,4'd9,4'd0,4'd7,4'd2,4'd4,4'd13,4'd14,
                         4'd11,4'd5,4'd6,4'd10,4'd1,4'd15,4'd8,4'd3};
            3'd1: row = {4'd4,4'd3,4'd13,4'd6,4'd8,4'd14,4'd11,4'd1,
                         4'd10,4'd5,4'd0,4'd9,4'd7,4'd2,4'd12,4'd15};
            3'd2: row = {4'd2,4'd5,4'd11,4'd0,4'd4,4'd14,4'd1,4'd13,
                         4'd15,4'd10,4'd12,4'd3,4'd9,4'd7,4'd6,4'd8};
            3'd3: row = {4'd14,4'd5,4'd7,4'd10,4'd4,4'd2,4'd1,4'd13,
                         4'd3,4'd6,4'd9,4'd12,4'd8,4'd11,4'd15,4'd0};
            3'd4: row = {4'd13,4'd7,4'd14,4'd9,4'd10,4'd4,4'd5,4'd2,
                         4'd6,4'd11,4'd0,4'd12,4'd3,4'd8,4'd15,4'd1};
            3'd5: row = {4'd1,4'd7,4'd6,4'd13,4'd8,4'd14,4'd3,4'd0,
                         4'd12,4'd9,4'd10,4'd4,4'd11,4'd2,4'd5,4'd15};
            3'd6: row = {4'd0,4'd10,4'd3,4'd13,4'd15,4'd1,4'd9,4'd14,
                         4'd11,4'd6,4'd4,4'd8,4'd5,4'd12,4'd2,4'd7};
            default: row = {4'd6,4'd5,4'd3,4'd9,4'd10,4'd12,4'd4,4'd7,
                            4'd11,4'd2,4'd8,4'd14,4'd0,4'd15,4'd13,4'd1};
        endcase
        return row[v*4 +: 4];
    endfunction

    function automatic nib_t inv_sbox(input logic [2:0] b, input nib_t v);
        nib_t r;
        r = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (sbox(b, 4'(i)) == v)
            begin
                r = 4'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] box128(input logic [127:0] x, input logic [2:0] b,
                                           input logic inv);
        logic [127:0] y;
        nib_t n, o;
        y = '0;
        for (int j = 0; j < 32; j++)
        begin
            n = {x[96+j], x[64+j], x[32+j], x[j]};
            o = inv ? inv_sbox(b, n) : sbox(b, n);
            y[j] = o[0];
            y[32+j] = o[1];
            y[64+j] = o[2];
            y[96+j] = o[3];
        end
        return y;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [127:0] lin_fwd(input logic [127:0] x);
        logic [31:0] a, b, c, d;
        a = x[31:0]; b = x[63:32]; c = x[95:64]; d = x[127:96];
        a = rotl(a, 13);
        c = rotl(c, 3);
        b = b ^ a ^ c;
        d = d ^ c ^ (a << 3);
        b = rotl(b, 1);
        d = rotl(d, 7);
        a = a ^ b ^ d;
        c = c ^ d ^ (b << 7);
        a = rotl(a, 5);
        c = rotl(c, 22);
        return {d, c, b, a};
    endfunction

    function automatic logic [127:0] lin_inv(input logic [127:0] x);
        logic [31:0] a, b, c, d;
        a = x[31:0]; b = x[63:32]; c = x[95:64]; d = x[127:96];
        c = rotl(c, 10);
        a = rotl(a, 27);
        c = c ^ d ^ (b << 7);
        a = a ^ b ^ d;
        d = rotl(d, 25);
        b = rotl(b, 31);
        d = d ^ c ^ (a << 3);
        b = b ^ a ^ c;
        c = rotl(c, 29);
        a = rotl(a, 19);
        return {d, c, b, a};
    endfunction

endpackage

// File: rtl/sbc_ctrl.sv
// Controller sequencing key expansion and the rounds of one item.
module sbc_ctrl #(
    parameter int ROUNDS  = sbc_pkg::ROUNDS_DEF,
    parameter int SUBKEYS = sbc_pkg::SUBKEYS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             mode,
    input  logic             key_write,
    output logic             busy,
    output logic             done,
    output sbc_pkg::dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_KEX  = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    localparam int KX_STEPS = 4 * SUBKEYS;

    state_t      state_reg, state_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [5:0]  round_reg, round_next;
    logic        mode_reg, mode_next;
    logic        ready_reg, ready_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            round_reg <= '0;
            mode_reg  <= 1'b0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            round_reg <= round_next;
            mode_reg  <= mode_next;
            ready_reg <= ready_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        round_next = round_reg;
        mode_next  = mode_reg;
        ready_next = ready_reg;
        cmd        = '0;
        cmd.mode   = mode_reg;
        cmd.round  = round_reg;
        cmd.kx_idx = cnt_reg[7:2];
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (key_write)
                begin
                    ready_next = 1'b0;
                end
                if (start)
                begin
                    cmd.load  = 1'b1;
                    cmd.mode  = mode;
                    mode_next = mode;
                    round_next = mode ? 6'(ROUNDS - 1) : 6'd0;
                    cnt_next  = '0;
                    cmd.kx_load = !ready_reg;
                    state_next = ready_reg ? ST_RUN : ST_KEX;
                end
            end
            ST_KEX:
            begin
                // one step past the last prekey word lets the last subkey reach the reads
                cmd.kx_step = 1'b1;
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == 8'(KX_STEPS))
                begin
                    ready_next = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.final_step = 1'b0;
                if (mode_reg)
                begin
                    if (round_reg == 6'd0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        round_next = round_reg - 6'd1;
                    end
                end
                else
                begin
                    if (round_reg == 6'(ROUNDS - 1))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        round_next = round_reg + 6'd1;
                    end
                end
            end
            ST_FIN:
            begin
                cmd.final_step = 1'b1;
                done = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.rk_round = round_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: rtl/sbc_datapath.sv
// Datapath: prekey generator, subkey store and shared round unit.
module sbc_datapath #(
    parameter int ROUNDS  = sbc_pkg::ROUNDS_DEF,
    parameter int SUBKEYS = sbc_pkg::SUBKEYS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sbc_pkg::dp_cmd_t  cmd,
    input  sbc_pkg::in_item_t in_item,
    input  logic [255:0]      key,
    output logic [127:0]      state_out
);

    logic [127:0] store_mem [SUBKEYS];
    logic [255:0] win_reg, win_next;
    logic [7:0]   widx_reg;
    logic [1:0]   wpos_reg;
    logic [95:0]  acc_reg;
    logic [127:0] x_reg, x_next;
    logic [127:0] rk_a_reg, rk_b_reg, rnd, tmp;
    logic [31:0]  neww;
    logic [127:0] kfull;
    logic [2:0]   kbox;
    logic [5:0]   rd_a, rd_b;

    assign neww = sbc_pkg::rotl(win_reg[31:0] ^ win_reg[127:96] ^ win_reg[191:160]
                  ^ win_reg[255:224] ^ sbc_pkg::GOLDEN_PHI ^ {24'd0, widx_reg}, 11);
    assign win_next = {neww, win_reg[255:32]};
    assign kfull = {neww, acc_reg};
    assign kbox  = 3'(6'd35 - cmd.kx_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widx_reg <= '0;
            wpos_reg <= '0;
        end
        else if (cmd.kx_load)
        begin
            widx_reg <= '0;
            wpos_reg <= '0;
        end
        else if (cmd.kx_step)
        begin
            widx_reg <= widx_reg + 8'd1;
            wpos_reg <= wpos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.kx_load)
        begin
            win_reg <= key;
        end
        else if (cmd.kx_step)
        begin
            win_reg <= win_next;
            case (wpos_reg)
                2'd0: acc_reg[31:0]  <= neww;
                2'd1: acc_reg[63:32] <= neww;
                2'd2: acc_reg[95:64] <= neww;
                default: store_mem[cmd.kx_idx] <= sbc_pkg::box128(kfull, kbox, 1'b0);
            endcase
        end
    end

    assign rd_a = cmd.rk_round;
    assign rd_b = cmd.rk_round + 6'd1;

    always_ff @(posedge clk)
    begin
        rk_a_reg <= store_mem[rd_a];
        rk_b_reg <= store_mem[rd_b];
    end

    always_comb
    begin
        tmp = '0;
        if (cmd.mode == 1'b0)
        begin
            tmp = sbc_pkg::box128(x_reg ^ rk_a_reg, cmd.round[2:0], 1'b0);
            if (cmd.round == 6'(ROUNDS - 1))
            begin
                rnd = tmp ^ rk_b_reg;
            end
            else
            begin
                rnd = sbc_pkg::lin_fwd(tmp);
            end
        end
        else
        begin
            if (cmd.round == 6'(ROUNDS - 1))
            begin
                tmp = x_reg ^ rk_b_reg;
            end
            else
            begin
                tmp = sbc_pkg::lin_inv(x_reg);
            end
            rnd = sbc_pkg::box128(tmp, cmd.round[2:0], 1'b1) ^ rk_a_reg;
        end
    end

    always_comb
    begin
        x_next = x_reg;
        if (cmd.load)
        begin
            x_next = {in_item.block_high, in_item.block_low};
        end
        else if (!cmd.kx_step && !cmd.final_step)
        begin
            x_next = rnd;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    assign state_out = x_reg;

endmodule

// File: rtl/serpent_block_cipher.sv
// Top level of the Serpent block cipher with a 256-bit key.
// Start an item when busy is low; done strobes one cycle with the result, which the
// receiver cannot stall. An item passes through the accept cycle that loads the block,
// 32 rounds on one shared round unit and the result cycle, so the next item can be
// accepted in the cycle after done. The first item after reset or a key write first
// expands the 33 subkeys, one prekey word per cycle, with a final step that fetches
// the first subkeys. Key writes are accepted only while busy is low.
module serpent_block_cipher #(
    parameter int ROUNDS  = sbc_pkg::ROUNDS_DEF,
    parameter int SUBKEYS = sbc_pkg::SUBKEYS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sbc_pkg::in_item_t  in_item,
    output logic               done,
    output sbc_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    logic [63:0] key_reg [4];
    logic        kw;
    sbc_pkg::dp_cmd_t cmd;
    logic [127:0] x;

    assign cfg_ready = !busy;
    assign kw = cfg_valid && cfg_ready && (cfg_index[7:2] == 6'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (kw)
        begin
            key_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    sbc_ctrl #(.ROUNDS(ROUNDS), .SUBKEYS(SUBKEYS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start && !busy),
        .mode      (in_item.mode),
        .key_write (kw),
        .busy      (busy),
        .done      (done),
        .cmd       (cmd)
    );

    sbc_datapath #(.ROUNDS(ROUNDS), .SUBKEYS(SUBKEYS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .key       ({key_reg[3], key_reg[2], key_reg[1], key_reg[0]}),
        .state_out (x)
    );

    assign out_item.result_low  = x[63:0];
    assign out_item.result_high = x[127:64];

endmodule
